>>> hdl/tes_pkg.sv
// Types and constants for the text encoding sniffer.
// No dependencies; imported by text_encoding_sniffer_top.
package tes_pkg;

  // One byte of the file plus framing flags
  typedef struct packed {
    logic [7:0] byte_value;
    logic       is_last;
    logic       empty_stream;
  } item_t;

  // One guess per file
  typedef struct packed {
    logic [2:0] guess_code;
    logic [1:0] confidence;
  } result_t;

  localparam logic [2:0] GUESS_NONE    = 3'd0;
  localparam logic [2:0] GUESS_UTF16LE = 3'd1;
  localparam logic [2:0] GUESS_UTF16BE = 3'd2;
  localparam logic [2:0] GUESS_UTF8    = 3'd3;
  localparam logic [2:0] GUESS_WIN1252 = 3'd4;
  localparam logic [2:0] GUESS_LATIN1  = 3'd5;

  localparam logic [1:0] CONF_UNSURE    = 2'd0;
  localparam logic [1:0] CONF_WEAK      = 2'd1;
  localparam logic [1:0] CONF_CONFIDENT = 2'd2;

  localparam logic [7:0] C1_LOW     = 8'h80;
  localparam logic [7:0] C1_HIGH    = 8'h9F;
  localparam logic [1:0] TOP2_CONT  = 2'b10;
  localparam logic [1:0] TOP2_LEAD  = 2'b11;

endpackage

>>> hdl/text_encoding_sniffer_top.sv
// Text encoding sniffer: counts UTF-8 / C1 / zero-byte statistics per file
// and emits one encoding guess on the last byte. Depends on tes_pkg.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+------------------------
//  item    | in        | item_valid / item_ready     | tes_pkg::item_t
//  result  | out       | result_valid / result_ready | tes_pkg::result_t
//
// One byte per cycle while item_ready is high. Counters update at the accepting
// edge; a last (or empty) transaction copies the final counts into a snapshot
// register, and the decision compares run on that snapshot and land in the
// result register when the snapshot moves on. The snapshot and result registers
// form a two-entry pipe; item_ready drops only when both are full and
// result_ready is low. Synchronous reset clears counters and valid flags.
module text_encoding_sniffer_top #(
  parameter longint unsigned MAX_BYTES = 16777216
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  tes_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output tes_pkg::result_t result
);
  import tes_pkg::*;

  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam int PW = CW + 10;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BYTES);

  // running counts
  logic [7:0]    previous_byte, previous_byte_next;
  logic [CW-1:0] byte_position, byte_position_next;
  logic [CW-1:0] good_cnt, good_cnt_next;
  logic [CW-1:0] bad_cnt, bad_cnt_next;
  logic [CW-1:0] c1_cnt, c1_cnt_next;
  logic [CW-1:0] zero_even_cnt, zero_even_cnt_next;
  logic [CW-1:0] zero_odd_cnt, zero_odd_cnt_next;

  // snapshot of a finished file
  logic          snap_valid;
  logic          snap_empty;
  logic [CW-1:0] snap_size, snap_le, snap_be, snap_good, snap_bad;
  logic          snap_c1_seen;

  logic item_fire, snap_move, file_end;
  logic cur_cont, prev_lead, prev_ascii;
  result_t decision;

  assign snap_move  = snap_valid && (!result_valid || result_ready);
  assign item_ready = !snap_valid || snap_move;
  assign item_fire  = item_valid && item_ready;
  assign file_end   = item.is_last || item.empty_stream;

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
    bump = (c < MAX_CNT) ? c + CW'(1) : c;
  endfunction

  assign cur_cont   = item.byte_value[7:6] == TOP2_CONT;
  assign prev_lead  = previous_byte[7:6] == TOP2_LEAD;
  assign prev_ascii = !previous_byte[7];

  always_comb begin
    previous_byte_next = previous_byte;
    byte_position_next = byte_position;
    good_cnt_next      = good_cnt;
    bad_cnt_next       = bad_cnt;
    c1_cnt_next        = c1_cnt;
    zero_even_cnt_next = zero_even_cnt;
    zero_odd_cnt_next  = zero_odd_cnt;
    if (byte_position < MAX_CNT) begin
      if (item.byte_value >= C1_LOW && item.byte_value <= C1_HIGH) begin
        c1_cnt_next = bump(c1_cnt);
      end
      if (byte_position != '0) begin
        if (cur_cont) begin
          if (prev_lead) begin
            good_cnt_next = bump(good_cnt);
          end else if (prev_ascii) begin
            bad_cnt_next = bump(bad_cnt);
          end
        end else begin
          if (prev_lead) begin
            bad_cnt_next = bump(bad_cnt);
          end
          if (previous_byte == 8'h00) begin
            if (byte_position[0]) begin
              zero_odd_cnt_next = bump(zero_odd_cnt);
            end else begin
              zero_even_cnt_next = bump(zero_even_cnt);
            end
          end
        end
      end
      previous_byte_next = item.byte_value;
      byte_position_next = byte_position + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_byte <= '0;
      byte_position <= '0;
      good_cnt      <= '0;
      bad_cnt       <= '0;
      c1_cnt        <= '0;
      zero_even_cnt <= '0;
      zero_odd_cnt  <= '0;
    end else if (item_fire) begin
      if (file_end) begin
        previous_byte <= '0;
        byte_position <= '0;
        good_cnt      <= '0;
        bad_cnt       <= '0;
        c1_cnt        <= '0;
        zero_even_cnt <= '0;
        zero_odd_cnt  <= '0;
      end else begin
        previous_byte <= previous_byte_next;
        byte_position <= byte_position_next;
        good_cnt      <= good_cnt_next;
        bad_cnt       <= bad_cnt_next;
        c1_cnt        <= c1_cnt_next;
        zero_even_cnt <= zero_even_cnt_next;
        zero_odd_cnt  <= zero_odd_cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (item_fire && file_end) begin
      snap_valid <= 1'b1;
    end else if (snap_move) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && file_end) begin
      snap_empty   <= item.empty_stream;
      snap_size    <= byte_position_next;
      snap_le      <= zero_even_cnt_next;
      snap_be      <= zero_odd_cnt_next;
      snap_good    <= good_cnt_next;
      snap_bad     <= bad_cnt_next;
      snap_c1_seen <= c1_cnt_next != '0;
    end
  end

  // Decision: floor divisions are replaced by exact compares against products
  logic          le_wins;
  logic [CW-1:0] minor, major;
  logic [PW-1:0] minor_x1000, major_x100, bad_x10, size_w;
  logic          utf16_ok;

  always_comb begin
    le_wins     = snap_le > snap_be;
    minor       = le_wins ? snap_be : snap_le;
    major       = le_wins ? snap_le : snap_be;
    size_w      = PW'(snap_size);
    minor_x1000 = PW'(minor) * PW'(1000);
    major_x100  = (PW'(major) + PW'(1)) * PW'(100);
    bad_x10     = PW'(snap_bad) * PW'(10);
    utf16_ok    = (minor_x1000 <= size_w) && (major_x100 > size_w) && (major >= CW'(2));
    decision    = '{guess_code: GUESS_NONE, confidence: CONF_UNSURE};
    if (snap_empty) begin
      decision = '{guess_code: GUESS_NONE, confidence: CONF_UNSURE};
    end else if (utf16_ok) begin
      decision.guess_code = le_wins ? GUESS_UTF16LE : GUESS_UTF16BE;
      decision.confidence = CONF_CONFIDENT;
    end else if (PW'(snap_good) > bad_x10) begin
      decision.guess_code = GUESS_UTF8;
      decision.confidence = CONF_CONFIDENT;
    end else begin
      decision.guess_code = snap_c1_seen ? GUESS_WIN1252 : GUESS_LATIN1;
      decision.confidence = (snap_bad == '0) ? CONF_UNSURE : CONF_WEAK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (snap_move) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_move) begin
      result <= decision;
    end
  end

  // Counters never run ahead of the byte position
  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (good_cnt <= byte_position) && (bad_cnt <= byte_position) &&
    (c1_cnt <= byte_position) && (zero_even_cnt <= byte_position) &&
    (zero_odd_cnt <= byte_position))
    else $error("counter exceeds byte position");

  a_position_sat: assert property (@(posedge clk) disable iff (rst)
    byte_position <= MAX_CNT)
    else $error("byte position past limit");

  a_clear_on_end: assert property (@(posedge clk) disable iff (rst)
    (item_fire && file_end) |=> (byte_position == '0) && snap_valid)
    else $error("state not cleared after end of file");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (snap_valid && result_valid && !result_ready) |-> !item_ready)
    else $error("accepted into a full pipe");

  a_snapshot_drains: assert property (@(posedge clk) disable iff (rst)
    snap_move |=> result_valid)
    else $error("snapshot moved without producing a result");

endmodule
